>>> design/cfgkw_pkg.sv
// shared types, codes and the keyword table of the config keyword tokenizer
// no dependencies; used by every module of the block and by the checker
`default_nettype none

package cfgkw_pkg;

    // result field widths as seen on the ports
    localparam int KIND_W  = 5;
    localparam int START_W = 16;
    localparam int LEN_W   = 16;
    localparam int LINE_W  = 20;

    // token kinds beyond the keyword numbers
    localparam logic [KIND_W-1:0] KIND_QUOTED = 5'd25;
    localparam logic [KIND_W-1:0] KIND_STRING = 5'd26;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd27;
    localparam logic [KIND_W-1:0] KIND_END    = 5'd28;

    // characters with a meaning to the scanner
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // keyword table
    localparam int KW_COUNT   = 25;
    localparam int KW_MAX_LEN = 7;
    localparam int KW_LEN_W   = 3;

    // keywords that count anywhere on a line
    localparam int KW_OPEN_BRACE = 13;
    localparam int KW_ON         = 16;
    localparam int KW_TO         = 18;
    localparam int KW_EVERY      = 20;

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd5,
        3'd7, 3'd4, 3'd4, 3'd1, 3'd1, 3'd6, 3'd2, 3'd6, 3'd2, 3'd6,
        3'd5, 3'd7, 3'd6, 3'd4, 3'd3
    };

    localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX_LEN] = '{
        '{"j", "o", "b", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "a", "m", "e", 8'h00, 8'h00, 8'h00},
        '{"u", "s", "e", "r", 8'h00, 8'h00, 8'h00},
        '{"c", "m", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "v", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "i", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "r", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "r", "d", "e", "r", 8'h00, 8'h00},
        '{"d", "i", "s", "a", "b", "l", "e"},
        '{"w", "a", "i", "t", 8'h00, 8'h00, 8'h00},
        '{"o", "n", "c", "e", 8'h00, 8'h00, 8'h00},
        '{"{", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"}", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "i", "s", "t", "e", "n", 8'h00},
        '{"o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "p", "o", "r", "t", 8'h00},
        '{"t", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "o", "u", "n", "c", "e", 8'h00},
        '{"e", "v", "e", "r", "y", 8'h00, 8'h00},
        '{"d", "e", "p", "e", "n", "d", "s"},
        '{"u", "l", "i", "m", "i", "t", 8'h00},
        '{"n", "i", "c", "e", 8'h00, 8'h00, 8'h00},
        '{"c", "p", "u", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_QUOTE,
        MODE_COMMENT,
        MODE_SKIP
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
        logic               last;
    } result_t;

    // results of one byte, in order; count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

`default_nettype wire

>>> design/cfgkw_match.sv
// keyword lookup: compares the word prefix and length against the keyword table
// depends on cfgkw_pkg
`default_nettype none

module cfgkw_match #(
    parameter int OFFSET_BITS = 16
) (
    input  logic [cfgkw_pkg::KW_MAX_LEN-1:0][7:0] prefix,
    input  logic [OFFSET_BITS-1:0]                tok_len,
    input  logic                                  began_line,
    output logic [cfgkw_pkg::KIND_W-1:0]          kind
);

    logic [cfgkw_pkg::KW_COUNT-1:0] hit;

    // one compare per keyword, all in parallel
    always_comb begin
        for (int k = 0; k < cfgkw_pkg::KW_COUNT; k++) begin
            hit[k] = (tok_len == OFFSET_BITS'(cfgkw_pkg::KW_LEN[k]));
            for (int i = 0; i < cfgkw_pkg::KW_MAX_LEN; i++) begin
                if (i < int'(cfgkw_pkg::KW_LEN[k]) &&
                    prefix[i] != cfgkw_pkg::KW_CHARS[k][i]) begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    // first hit wins; most keywords only count at the head of a line
    always_comb begin
        logic found;
        found = 1'b0;
        kind  = cfgkw_pkg::KIND_STRING;
        for (int k = 0; k < cfgkw_pkg::KW_COUNT; k++) begin
            if (!found && hit[k]) begin
                found = 1'b1;
                if (began_line || k == cfgkw_pkg::KW_OPEN_BRACE || k == cfgkw_pkg::KW_ON ||
                    k == cfgkw_pkg::KW_TO || k == cfgkw_pkg::KW_EVERY) begin
                    kind = cfgkw_pkg::KIND_W'(k);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/cfgkw_scan.sv
// scanner state and per-byte next-state logic; forms up to two results per byte
// depends on cfgkw_pkg and cfgkw_match
`default_nettype none

module cfgkw_scan #(
    parameter int LONGEST_KEYWORD = 7,
    parameter int OFFSET_BITS     = 16,
    parameter int LINE_BITS       = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cfgkw_pkg::LINE_W-1:0]        cfg_wdata,
    input  logic                                step,
    input  logic [7:0]                          in_byte,
    input  logic                                in_last,
    output cfgkw_pkg::result_pair_t             res
);

    localparam logic [OFFSET_BITS-1:0] OffMax   = '1;
    localparam logic [LINE_BITS-1:0]   LineMax  = '1;
    localparam logic [32:0]            LineMaxW = (33'd1 << LINE_BITS) - 33'd1;

    function automatic logic [LINE_BITS-1:0] clamp_line(input logic [cfgkw_pkg::LINE_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > LineMaxW) ? LineMaxW[LINE_BITS-1:0] : w[LINE_BITS-1:0];
    endfunction

    cfgkw_pkg::scan_mode_t      mode_reg, mode_next;
    logic                       only_space_reg, only_space_next;
    logic                       began_reg, began_next;
    logic [7:0]                 prefix_reg [LONGEST_KEYWORD];
    logic [7:0]                 prefix_next [LONGEST_KEYWORD];
    logic [OFFSET_BITS-1:0]     start_reg, start_next;
    logic [OFFSET_BITS-1:0]     len_reg, len_next;
    logic [OFFSET_BITS-1:0]     offset_reg, offset_next;
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic [cfgkw_pkg::LINE_W-1:0] first_line_reg;

    logic                       is_space, is_lf;
    logic [OFFSET_BITS-1:0]     len_inc, offset_inc;
    logic [LINE_BITS-1:0]       line_inc, line_after;
    logic                       tok_v, tok_is_word;
    logic [cfgkw_pkg::KIND_W-1:0] tok_kind_fixed, word_kind;
    logic [cfgkw_pkg::KW_MAX_LEN-1:0][7:0] match_prefix;
    logic [31:0]                start32, len32, line32, end_start32, end_line32;
    cfgkw_pkg::result_t         tok_res, end_res;

    assign is_lf    = (in_byte == cfgkw_pkg::CH_LF);
    assign is_space = (in_byte == cfgkw_pkg::CH_SPACE) || (in_byte == cfgkw_pkg::CH_TAB) ||
                      (in_byte == cfgkw_pkg::CH_CR) || is_lf;

    assign len_inc    = (len_reg == OffMax) ? len_reg : len_reg + OFFSET_BITS'(1);
    assign offset_inc = (offset_reg == OffMax) ? offset_reg : offset_reg + OFFSET_BITS'(1);
    assign line_inc   = (line_reg == LineMax) ? line_reg : line_reg + LINE_BITS'(1);

    always_comb begin
        mode_next       = mode_reg;
        only_space_next = only_space_reg;
        began_next      = began_reg;
        prefix_next     = prefix_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        line_after      = line_reg;
        tok_v           = 1'b0;
        tok_is_word     = 1'b0;
        tok_kind_fixed  = cfgkw_pkg::KIND_ERROR;

        unique case (mode_reg)
            cfgkw_pkg::MODE_IDLE: begin
                if (is_space) begin
                    if (is_lf) begin
                        line_after      = line_inc;
                        only_space_next = 1'b1;
                    end
                end else if (in_byte == cfgkw_pkg::CH_HASH) begin
                    mode_next       = cfgkw_pkg::MODE_COMMENT;
                    only_space_next = 1'b0;
                end else begin
                    start_next      = offset_reg;
                    len_next        = OFFSET_BITS'(1);
                    began_next      = only_space_reg;
                    only_space_next = 1'b0;
                    if (in_byte == cfgkw_pkg::CH_QUOTE) begin
                        mode_next = cfgkw_pkg::MODE_QUOTE;
                        tok_v     = in_last;
                    end else begin
                        mode_next      = cfgkw_pkg::MODE_WORD;
                        prefix_next[0] = in_byte;
                        tok_v          = in_last;
                        tok_is_word    = 1'b1;
                    end
                end
            end
            cfgkw_pkg::MODE_WORD: begin
                tok_is_word = 1'b1;
                if (is_space) begin
                    tok_v     = 1'b1;
                    mode_next = cfgkw_pkg::MODE_IDLE;
                    if (is_lf) begin
                        line_after      = line_inc;
                        only_space_next = 1'b1;
                    end
                end else begin
                    for (int i = 0; i < LONGEST_KEYWORD; i++) begin
                        if (len_reg == OFFSET_BITS'(i)) begin
                            prefix_next[i] = in_byte;
                        end
                    end
                    len_next = len_inc;
                    tok_v    = in_last;
                end
            end
            cfgkw_pkg::MODE_QUOTE: begin
                len_next = len_inc;
                if (in_byte == cfgkw_pkg::CH_QUOTE) begin
                    tok_v          = 1'b1;
                    tok_kind_fixed = cfgkw_pkg::KIND_QUOTED;
                    mode_next      = cfgkw_pkg::MODE_IDLE;
                end else if (is_lf) begin
                    tok_v     = 1'b1;
                    mode_next = cfgkw_pkg::MODE_SKIP;
                end else begin
                    tok_v = in_last;
                end
            end
            cfgkw_pkg::MODE_COMMENT: begin
                if (is_lf) begin
                    line_after      = line_inc;
                    only_space_next = 1'b1;
                    mode_next       = cfgkw_pkg::MODE_IDLE;
                end
            end
            cfgkw_pkg::MODE_SKIP: begin
            end
            default: begin
            end
        endcase

        line_next   = line_after;
        offset_next = offset_inc;
        // buffer end: start afresh
        if (in_last) begin
            mode_next       = cfgkw_pkg::MODE_IDLE;
            only_space_next = 1'b1;
            began_next      = 1'b0;
            offset_next     = '0;
            start_next      = '0;
            len_next        = '0;
            line_next       = clamp_line(first_line_reg);
        end
    end

    // keyword match runs on the token as it stands after this byte
    always_comb begin
        for (int i = 0; i < cfgkw_pkg::KW_MAX_LEN; i++) begin
            match_prefix[i] = prefix_next[i];
        end
    end

    cfgkw_match #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .prefix     (match_prefix),
        .tok_len    (tok_is_word && mode_reg == cfgkw_pkg::MODE_IDLE ? OFFSET_BITS'(1)
                                                                     : (is_space ? len_reg
                                                                                 : len_inc)),
        .began_line (mode_reg == cfgkw_pkg::MODE_IDLE ? only_space_reg : began_reg),
        .kind       (word_kind)
    );

    always_comb begin
        start32     = 32'(mode_reg == cfgkw_pkg::MODE_IDLE ? offset_reg : start_reg);
        len32       = 32'(mode_reg == cfgkw_pkg::MODE_IDLE ? OFFSET_BITS'(1)
                                                           : (tok_is_word && is_space ? len_reg
                                                                                      : len_inc));
        line32      = 32'(line_reg);
        end_start32 = 32'(offset_inc);
        end_line32  = 32'(line_after);

        tok_res.kind   = tok_is_word ? word_kind : tok_kind_fixed;
        tok_res.start  = start32[cfgkw_pkg::START_W-1:0];
        tok_res.length = len32[cfgkw_pkg::LEN_W-1:0];
        tok_res.line   = line32[cfgkw_pkg::LINE_W-1:0];
        tok_res.last   = !in_last;

        end_res.kind   = cfgkw_pkg::KIND_END;
        end_res.start  = end_start32[cfgkw_pkg::START_W-1:0];
        end_res.length = '0;
        end_res.line   = end_line32[cfgkw_pkg::LINE_W-1:0];
        end_res.last   = 1'b1;

        res.count  = {tok_v & in_last, tok_v ^ in_last};
        res.first  = tok_v ? tok_res : end_res;
        res.second = end_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= cfgkw_pkg::MODE_IDLE;
            only_space_reg <= 1'b1;
            began_reg      <= 1'b0;
            offset_reg     <= '0;
            first_line_reg <= cfgkw_pkg::LINE_W'(1);
            line_reg       <= LINE_BITS'(1);
        end else begin
            if (cfg_we) begin
                first_line_reg <= cfg_wdata;
            end
            if (step) begin
                mode_reg       <= mode_next;
                only_space_reg <= only_space_next;
                began_reg      <= began_next;
                offset_reg     <= offset_next;
                line_reg       <= line_next;
            end else if (cfg_we && offset_reg == '0 && mode_reg == cfgkw_pkg::MODE_IDLE) begin
                line_reg <= clamp_line(cfg_wdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            prefix_reg <= prefix_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
        end
    end

endmodule

`default_nettype wire

>>> design/cfgkw_fifo.sv
// four-entry result queue: takes one or two results per cycle, gives one
// depends on cfgkw_pkg
`default_nettype none

module cfgkw_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_en,
    input  cfgkw_pkg::result_pair_t push,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output cfgkw_pkg::result_t      out_data
);

    cfgkw_pkg::result_t                 entries_reg [cfgkw_pkg::FIFO_DEPTH];
    logic [cfgkw_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [cfgkw_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [cfgkw_pkg::FIFO_CNT_W-1:0]   fill_reg, fill_next;
    logic [1:0]                         n_push;
    logic                               pop;

    assign n_push    = push_en ? push.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (fill_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    // room for the worst case of two results from one byte
    assign room      = (fill_reg <= cfgkw_pkg::FIFO_CNT_W'(cfgkw_pkg::FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + cfgkw_pkg::FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + cfgkw_pkg::FIFO_PTR_W'(pop);
        fill_next   = fill_reg + cfgkw_pkg::FIFO_CNT_W'(n_push)
                               - cfgkw_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2) begin
            entries_reg[wr_ptr_reg + cfgkw_pkg::FIFO_PTR_W'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

>>> design/config_keyword_tokenizer_core.sv
// config keyword tokenizer, top level: input register, scanner, result queue
// path: a byte held in the input register is scanned once the queue has room for both
//   of its results, which are written to the queue, the end result behind the first
// throughput: one byte per cycle while the queue has room; the result port gives
//   one transaction per cycle; the four-entry queue absorbs a last byte's end result
// reset: aresetn synchronous active low; clears scan mode, offset, queue, and loads line 1
`default_nettype none

module config_keyword_tokenizer_core #(
    parameter int LONGEST_KEYWORD = 7,
    parameter int OFFSET_BITS     = 16,
    parameter int LINE_BITS       = 20
) (
    input  logic        aclk,
    input  logic        aresetn,

    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic        s_tlast,    // last_byte

    // token stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [15:0] token_start, [31:16] token_length,
                                    // [51:32] token_line, [55:52] zero
    output logic [4:0]  m_tuser,    // [4:0] token_kind
    output logic        m_tlast,    // last_of_run

    // first line number register
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);

    // input register stage
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;

    logic               room;
    logic               step;
    cfgkw_pkg::result_pair_t res;
    cfgkw_pkg::result_t      head;

    // a held byte is scanned once the queue can take both of its results
    assign step     = in_valid_reg && room;
    // new transaction is taken when no byte is held or while the held one is being scanned
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // scanner: mode, counters, word prefix and result forming
    cfgkw_scan #(
        .LONGEST_KEYWORD (LONGEST_KEYWORD),
        .OFFSET_BITS     (OFFSET_BITS),
        .LINE_BITS       (LINE_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res       (res)
    );

    // result queue decouples the output side from scanning
    cfgkw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (step),
        .push      (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // output packing
    assign m_tdata = {4'b0000, head.line, head.length, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

>>> design/config_keyword_tokenizer_core_chk.sv
// port-level checker for the config keyword tokenizer, bound to the top level
// depends on cfgkw_pkg and config_keyword_tokenizer_core
`default_nettype none

module config_keyword_tokenizer_core_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // end token is zero length and closes its run
    a_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == cfgkw_pkg::KIND_END |-> m_tdata[31:16] == 16'd0 && m_tlast)
        else $error("malformed end token");

    // a closed quote holds at least both quote marks
    a_quote_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == cfgkw_pkg::KIND_QUOTED |-> m_tdata[31:16] >= 16'd2)
        else $error("quoted token too short");

    // a token that is not the run's last is always followed by the end token
    a_end_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == cfgkw_pkg::KIND_END)
        else $error("end token missing after token");

endmodule

bind config_keyword_tokenizer_core config_keyword_tokenizer_core_chk u_chk (.*);

`default_nettype wire
